@@ hw/rtl/sdcd_pkg.sv @@
// sdcd_pkg: shared constants for the sd clock divider search
// field widths, register reset value, control word layout
// no dependencies
`default_nettype none

package sdcd_pkg;

    localparam int TARGET_W = 32;
    localparam int REF_W    = 32;
    localparam int PCODE_W  = 8;
    localparam int DCODE_W  = 4;
    localparam int WORD_W   = 20;

    localparam int MAX_PRESCALE_DEF = 256;
    localparam int MAX_DIVISOR_DEF  = 16;

    localparam logic [REF_W-1:0] REF_CLOCK_RESET = 32'd200000000;

    localparam int BASE_SHIFT     = 4;
    localparam int TIMEOUT_W      = 4;
    localparam int TIMEOUT_SHIFT  = 16;
    localparam int PRESCALE_SHIFT = 8;
    localparam int DIVISOR_SHIFT  = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_EXP = 4'd14;

endpackage

`default_nettype wire

@@ hw/rtl/sdcd_if.sv @@
// sdcd_req_if, sdcd_rsp_if: valid/ready channels of the divider search
// depends on sdcd_pkg for field widths
`default_nettype none

interface sdcd_req_if;
    logic                          valid;
    logic                          ready;
    logic [sdcd_pkg::TARGET_W-1:0] target_hz;

    modport source (output valid, output target_hz, input ready);
    modport sink   (input valid, input target_hz, output ready);
endinterface

interface sdcd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sdcd_pkg::PCODE_W-1:0] prescale_code;
    logic [sdcd_pkg::DCODE_W-1:0] divisor_code;
    logic [sdcd_pkg::WORD_W-1:0]  control_word;

    modport source (output valid, output prescale_code, output divisor_code,
                    output control_word, input ready);
    modport sink   (input valid, input prescale_code, input divisor_code,
                    input control_word, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sd_clock_divider_search.sv @@
// sd_clock_divider_search: prescaler and divisor search, depends on sdcd_pkg and sdcd_if
// P prescaler doublings (up to log2 of the cap) through a shift,
// D divisor steps (up to the cap minus one) through one shared adder and compare
// the next item is taken only in idle, once the last result is loaded into the output register
// a result still waiting stalls the last divisor step until the output register frees
// reset clears control state and loads the reference clock reset value
`default_nettype none

module sd_clock_divider_search #(
    parameter int MAX_PRESCALE = sdcd_pkg::MAX_PRESCALE_DEF,
    parameter int MAX_DIVISOR  = sdcd_pkg::MAX_DIVISOR_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [sdcd_pkg::REF_W-1:0] cfg_wdata,
    sdcd_req_if.sink                        req,
    sdcd_rsp_if.source                      rsp
);

    localparam int PRE_W = $clog2(MAX_PRESCALE) + 1;
    localparam int SH_W  = $clog2($clog2(MAX_PRESCALE) + 1);
    localparam int DIV_W = $clog2(MAX_DIVISOR + 1);
    localparam int T1_W  = sdcd_pkg::TARGET_W + 1;
    localparam int ACC_W = T1_W + DIV_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_DIV
    } state_t;

    state_t                       state_reg, state_next;
    logic [sdcd_pkg::REF_W-1:0]   ref_reg, ref_next;
    logic [sdcd_pkg::REF_W-1:0]   rs_reg, rs_next;
    logic [T1_W-1:0]              t1_reg, t1_next;
    logic [SH_W-1:0]              sh_reg, sh_next;
    logic [DIV_W-1:0]             post_reg, post_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [sdcd_pkg::PCODE_W-1:0] pcode_reg, pcode_next;
    logic [sdcd_pkg::DCODE_W-1:0] dcode_reg, dcode_next;

    logic [PRE_W-1:0] pre;
    logic             pre_go;
    logic             div_go;
    logic             slot_free;

    assign pre       = PRE_W'(1) << sh_reg;
    assign pre_go    = (T1_W'(rs_reg >> sdcd_pkg::BASE_SHIFT) >= t1_reg)
                       && (pre < PRE_W'(MAX_PRESCALE));
    assign div_go    = (ACC_W'(rs_reg) >= acc_reg) && (post_reg < DIV_W'(MAX_DIVISOR));
    assign slot_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        rs_next        = rs_reg;
        t1_next        = t1_reg;
        sh_next        = sh_reg;
        post_next      = post_reg;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg;
        pcode_next     = pcode_reg;
        dcode_next     = dcode_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            ref_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    rs_next    = ref_reg;
                    t1_next    = T1_W'(req.target_hz) + T1_W'(1);
                    sh_next    = '0;
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (pre_go)
                begin
                    rs_next = rs_reg >> 1;
                    sh_next = sh_reg + SH_W'(1);
                end
                else
                begin
                    post_next  = DIV_W'(1);
                    acc_next   = ACC_W'(t1_reg);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_go)
                begin
                    post_next = post_reg + DIV_W'(1);
                    acc_next  = acc_reg + ACC_W'(t1_reg);
                end
                else if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    pcode_next     = sdcd_pkg::PCODE_W'(pre >> 1);
                    dcode_next     = sdcd_pkg::DCODE_W'(post_reg - DIV_W'(1));
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_reg       <= sdcd_pkg::REF_CLOCK_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg    <= rs_next;
        t1_reg    <= t1_next;
        sh_reg    <= sh_next;
        post_reg  <= post_next;
        acc_reg   <= acc_next;
        pcode_reg <= pcode_next;
        dcode_reg <= dcode_next;
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.prescale_code = pcode_reg;
    assign rsp.divisor_code  = dcode_reg;
    assign rsp.control_word  =
        (sdcd_pkg::WORD_W'(sdcd_pkg::TIMEOUT_EXP) << sdcd_pkg::TIMEOUT_SHIFT)
        | (sdcd_pkg::WORD_W'(pcode_reg) << sdcd_pkg::PRESCALE_SHIFT)
        | (sdcd_pkg::WORD_W'(dcode_reg) << sdcd_pkg::DIVISOR_SHIFT);

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == ST_PRE)
        else $error("accepted item did not start the prescaler search");

    a_pcode_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot0(rsp.prescale_code))
        else $error("prescale code is not a power of two");

    a_post_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> post_reg <= DIV_W'(MAX_DIVISOR) && post_reg != '0)
        else $error("divisor left its range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> state_reg != ST_DIV || div_go || rsp.valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire
